@@ hdl/rgb_to_hsv_pixel_macros.svh @@
// Assertion macros for the RGB to HSV pixel converter.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// Check that a condition implies another at the same clock edge
`define RTHP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_hsv_pixel: same-cycle check failed");

// Check that a condition implies another at the next clock edge
`define RTHP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

@@ hdl/rthp_pkg.sv @@
// Shared types for the RGB to HSV pixel converter.
// Used by the sort and prep stages, the divider cells and the top level.
`default_nettype none

package rthp_pkg;

	// Which channel holds the maximum, with red split on the sign of G-B
	typedef enum logic [1:0] {
		SEC_RED_GE,
		SEC_RED_LT,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Special-case flags that ride along the divider chain
	typedef struct packed {
		logic hue_zero;
		logic sat_zero;
		logic sat_full;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/rthp_rgb_if.sv @@
// Valid/ready channel carrying one RGB pixel.
// No dependencies.
`default_nettype none

interface rthp_rgb_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] red_in;
	logic [SAMPLE_BITS-1:0] green_in;
	logic [SAMPLE_BITS-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

`default_nettype wire

@@ hdl/rthp_hsv_if.sv @@
// Valid/ready channel carrying one HSV pixel.
// No dependencies.
`default_nettype none

interface rthp_hsv_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] hue_out;
	logic [SAMPLE_BITS-1:0] sat_out;
	logic [SAMPLE_BITS-1:0] value_out;

	modport source (output valid, output hue_out, output sat_out, output value_out, input ready);
	modport sink (input valid, input hue_out, input sat_out, input value_out, output ready);
endinterface

`default_nettype wire

@@ hdl/rgb_to_hsv_pixel.sv @@
// RGB to HSV pixel converter, top level.
// Channels: pix_in (rthp_rgb_if, sink) takes red_in, green_in, blue_in as unsigned
// fractions where all ones means 1.0; pix_out (rthp_hsv_if, source) gives hue_out as
// a fraction of a full turn, sat_out as delta over max and value_out as the max.
// A transaction happens on a rising edge with valid and ready both high.
// Throughput: one pixel per clock while pix_out is ready; a new pixel can enter every
// cycle until an output stall fills the chain. The path from input transaction to output
// valid runs through one sort stage, one prep stage, then one divider cell per quotient bit.
// The divider is a chain of SAMPLE_BITS cells; each cell produces one hue and one
// saturation quotient bit and passes the remainders on to its neighbor.
// Every stage has its own valid bit and moves when the stage after it is empty
// or moving, so bubbles close up and input keeps flowing while the output stalls
// until the whole chain is full; a stalled result holds on pix_out.
// Reset clears all valid bits; payload registers are not reset and there is no clearing pass.
// Depends on rthp_pkg, rthp_rgb_if, rthp_hsv_if, rthp_sort, rthp_prep, rthp_cell
// and rgb_to_hsv_pixel_macros.svh.
`default_nettype none

`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rthp_rgb_if.sink   pix_in,
	rthp_hsv_if.source pix_out
);

	localparam int HW = SAMPLE_BITS + 3;

	logic                   s_valid, s_ready;
	logic [SAMPLE_BITS-1:0] s_red, s_green, s_blue, s_max, s_delta;
	rthp_pkg::sector_t      s_sector;

	logic [SAMPLE_BITS:0]                  cv, cr;
	rthp_pkg::cell_ctl_t [SAMPLE_BITS:0]   cctl;
	logic [SAMPLE_BITS:0][HW-1:0]          chrem, chden;
	logic [SAMPLE_BITS:0][SAMPLE_BITS-1:0] chq, csrem, csden, csq, cval;

	// Sort stage
	rthp_sort #(.SAMPLE_BITS(SAMPLE_BITS)) u_sort (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.red        (pix_in.red_in),
		.green      (pix_in.green_in),
		.blue       (pix_in.blue_in),
		.out_valid  (s_valid),
		.out_ready  (s_ready),
		.out_red    (s_red),
		.out_green  (s_green),
		.out_blue   (s_blue),
		.out_max    (s_max),
		.out_delta  (s_delta),
		.out_sector (s_sector)
	);

	// Prep stage feeds the head of the cell chain
	rthp_prep #(.SAMPLE_BITS(SAMPLE_BITS)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.red       (s_red),
		.green     (s_green),
		.blue      (s_blue),
		.max_val   (s_max),
		.delta     (s_delta),
		.sector    (s_sector),
		.out_valid (cv[0]),
		.out_ready (cr[0]),
		.out_ctl   (cctl[0]),
		.out_hrem  (chrem[0]),
		.out_hden  (chden[0]),
		.out_srem  (csrem[0]),
		.out_sden  (csden[0])
	);

	// Quotients start empty; value is the divisor of the saturation path
	assign chq[0]  = '0;
	assign csq[0]  = '0;
	assign cval[0] = csden[0];

	// Chain of divider cells, one quotient bit each
	for (genvar k = 0; k < SAMPLE_BITS; k++) begin : g_cell
		rthp_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_ctl    (cctl[k]),
			.in_hrem   (chrem[k]),
			.in_hden   (chden[k]),
			.in_hq     (chq[k]),
			.in_srem   (csrem[k]),
			.in_sden   (csden[k]),
			.in_sq     (csq[k]),
			.in_value  (cval[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_ctl   (cctl[k+1]),
			.out_hrem  (chrem[k+1]),
			.out_hden  (chden[k+1]),
			.out_hq    (chq[k+1]),
			.out_srem  (csrem[k+1]),
			.out_sden  (csden[k+1]),
			.out_sq    (csq[k+1]),
			.out_value (cval[k+1])
		);
	end

	// Last cell is the output register; apply the special cases on the way out
	assign pix_out.valid     = cv[SAMPLE_BITS];
	assign cr[SAMPLE_BITS]   = pix_out.ready;
	assign pix_out.hue_out   = cctl[SAMPLE_BITS].hue_zero ? '0 : chq[SAMPLE_BITS];
	assign pix_out.sat_out   = cctl[SAMPLE_BITS].sat_zero ? '0 :
		(cctl[SAMPLE_BITS].sat_full ? '1 : csq[SAMPLE_BITS]);
	assign pix_out.value_out = cval[SAMPLE_BITS];

	// Black pixels leave with zero hue and saturation
	`RTHP_ASSERT_SAME(a_black_out, pix_out.valid && (pix_out.value_out == '0),
		(pix_out.sat_out == '0) && (pix_out.hue_out == '0))
	// Any hue implies some saturation
	`RTHP_ASSERT_SAME(a_hue_sat, pix_out.valid && (pix_out.hue_out != '0),
		pix_out.sat_out != '0)
	// Gray flag at the chain head matches a zero hue divisor
	`RTHP_ASSERT_SAME(a_gray_den, cv[0], cctl[0].hue_zero == (chden[0] == '0))
	// A prep item that is refused stays in place
	`RTHP_ASSERT_NEXT(a_prep_hold, cv[0] && !cr[0], cv[0] && $stable(chden[0]))

endmodule

`default_nettype wire

@@ hdl/rthp_sort.sv @@
// First stage: finds max, delta and the hue sector of one pixel.
// Depends on rthp_pkg.
`default_nettype none

module rthp_sort #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] red,
	input  wire logic [SAMPLE_BITS-1:0] green,
	input  wire logic [SAMPLE_BITS-1:0] blue,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [SAMPLE_BITS-1:0]      out_red,
	output logic [SAMPLE_BITS-1:0]      out_green,
	output logic [SAMPLE_BITS-1:0]      out_blue,
	output logic [SAMPLE_BITS-1:0]      out_max,
	output logic [SAMPLE_BITS-1:0]      out_delta,
	output rthp_pkg::sector_t           out_sector
);

	logic                   valid_q;
	logic                   advance;
	logic                   b_ge_r, b_ge_g, g_ge_r, r_le_g, r_le_b, g_le_b;
	logic [SAMPLE_BITS-1:0] mx, mn;
	rthp_pkg::sector_t      sector;
	logic [SAMPLE_BITS-1:0] red_q, green_q, blue_q, max_q, delta_q;
	rthp_pkg::sector_t      sector_q;

	// Pairwise compares, all independent
	assign b_ge_r = blue >= red;
	assign b_ge_g = blue >= green;
	assign g_ge_r = green >= red;
	assign r_le_g = red <= green;
	assign r_le_b = red <= blue;
	assign g_le_b = green <= blue;

	// Pick max with blue over green over red on ties, and the matching sector
	always_comb begin
		if (b_ge_r && b_ge_g) begin
			mx     = blue;
			sector = rthp_pkg::SEC_BLUE;
		end else if (g_ge_r) begin
			mx     = green;
			sector = rthp_pkg::SEC_GREEN;
		end else begin
			mx     = red;
			sector = g_le_b && (green != blue) ? rthp_pkg::SEC_RED_LT : rthp_pkg::SEC_RED_GE;
		end
		if (r_le_g && r_le_b)
			mn = red;
		else if (g_le_b)
			mn = green;
		else
			mn = blue;
	end

	assign advance  = !valid_q || out_ready;
	assign in_ready = advance;

	// Advance the stage when the next one can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= in_valid;
	end

	// Load payload on a transaction
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			red_q    <= red;
			green_q  <= green;
			blue_q   <= blue;
			max_q    <= mx;
			delta_q  <= mx - mn;
			sector_q <= sector;
		end
	end

	assign out_valid  = valid_q;
	assign out_red    = red_q;
	assign out_green  = green_q;
	assign out_blue   = blue_q;
	assign out_max    = max_q;
	assign out_delta  = delta_q;
	assign out_sector = sector_q;

endmodule

`default_nettype wire

@@ hdl/rthp_prep.sv @@
// Second stage: forms the hue numerator and divisor, the saturation operands and the special-case flags.
// Depends on rthp_pkg.
`default_nettype none

module rthp_prep #(
	parameter int SAMPLE_BITS = 16,
	localparam int HW = SAMPLE_BITS + 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] red,
	input  wire logic [SAMPLE_BITS-1:0] green,
	input  wire logic [SAMPLE_BITS-1:0] blue,
	input  wire logic [SAMPLE_BITS-1:0] max_val,
	input  wire logic [SAMPLE_BITS-1:0] delta,
	input  wire rthp_pkg::sector_t      sector,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rthp_pkg::cell_ctl_t         out_ctl,
	output logic [HW-1:0]               out_hrem,
	output logic [HW-1:0]               out_hden,
	output logic [SAMPLE_BITS-1:0]      out_srem,
	output logic [SAMPLE_BITS-1:0]      out_sden
);

	logic                   valid_q;
	logic                   advance;
	logic [HW-1:0]          d_w, den, num;
	rthp_pkg::cell_ctl_t    ctl;
	rthp_pkg::cell_ctl_t    ctl_q;
	logic [HW-1:0]          hrem_q, hden_q;
	logic [SAMPLE_BITS-1:0] srem_q, sden_q;

	assign d_w = HW'(delta);
	assign den = (d_w << 2) + (d_w << 1);

	// Hue numerator for each sector
	always_comb begin
		unique case (sector)
			rthp_pkg::SEC_BLUE:   num = (d_w << 2) + HW'(red) - HW'(green);
			rthp_pkg::SEC_GREEN:  num = (d_w << 1) + HW'(blue) - HW'(red);
			rthp_pkg::SEC_RED_LT: num = den + HW'(green) - HW'(blue);
			default:              num = HW'(green) - HW'(blue);
		endcase
	end

	// Gray gives zero hue, black zero saturation, zero minimum full saturation
	assign ctl.hue_zero = delta == '0;
	assign ctl.sat_zero = max_val == '0;
	assign ctl.sat_full = (max_val != '0) && (delta == max_val);

	assign advance  = !valid_q || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			ctl_q  <= ctl;
			hrem_q <= num;
			hden_q <= den;
			srem_q <= delta;
			sden_q <= max_val;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_hrem  = hrem_q;
	assign out_hden  = hden_q;
	assign out_srem  = srem_q;
	assign out_sden  = sden_q;

endmodule

`default_nettype wire

@@ hdl/rthp_cell.sv @@
// Divider cell: one restoring quotient bit for hue and one for saturation.
// Depends on rthp_pkg.
`default_nettype none

module rthp_cell #(
	parameter int SAMPLE_BITS = 16,
	localparam int HW = SAMPLE_BITS + 3
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire rthp_pkg::cell_ctl_t    in_ctl,
	input  wire logic [HW-1:0]          in_hrem,
	input  wire logic [HW-1:0]          in_hden,
	input  wire logic [SAMPLE_BITS-1:0] in_hq,
	input  wire logic [SAMPLE_BITS-1:0] in_srem,
	input  wire logic [SAMPLE_BITS-1:0] in_sden,
	input  wire logic [SAMPLE_BITS-1:0] in_sq,
	input  wire logic [SAMPLE_BITS-1:0] in_value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output rthp_pkg::cell_ctl_t         out_ctl,
	output logic [HW-1:0]               out_hrem,
	output logic [HW-1:0]               out_hden,
	output logic [SAMPLE_BITS-1:0]      out_hq,
	output logic [SAMPLE_BITS-1:0]      out_srem,
	output logic [SAMPLE_BITS-1:0]      out_sden,
	output logic [SAMPLE_BITS-1:0]      out_sq,
	output logic [SAMPLE_BITS-1:0]      out_value
);

	logic                   valid_q;
	logic                   advance;
	logic [HW:0]            h_sh;
	logic [SAMPLE_BITS:0]   s_sh;
	logic                   h_ge, s_ge;
	rthp_pkg::cell_ctl_t    ctl_q;
	logic [HW-1:0]          hrem_q, hden_q;
	logic [SAMPLE_BITS-1:0] hq_q, srem_q, sden_q, sq_q, value_q;

	// Shift remainder, subtract divisor where it fits
	assign h_sh = {in_hrem, 1'b0};
	assign s_sh = {in_srem, 1'b0};
	assign h_ge = h_sh >= {1'b0, in_hden};
	assign s_ge = s_sh >= {1'b0, in_sden};

	assign advance  = !valid_q || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			ctl_q   <= in_ctl;
			hrem_q  <= h_ge ? HW'(h_sh - {1'b0, in_hden}) : HW'(h_sh);
			hden_q  <= in_hden;
			hq_q    <= {in_hq[SAMPLE_BITS-2:0], h_ge};
			srem_q  <= s_ge ? SAMPLE_BITS'(s_sh - {1'b0, in_sden}) : SAMPLE_BITS'(s_sh);
			sden_q  <= in_sden;
			sq_q    <= {in_sq[SAMPLE_BITS-2:0], s_ge};
			value_q <= in_value;
		end
	end

	assign out_valid = valid_q;
	assign out_ctl   = ctl_q;
	assign out_hrem  = hrem_q;
	assign out_hden  = hden_q;
	assign out_hq    = hq_q;
	assign out_srem  = srem_q;
	assign out_sden  = sden_q;
	assign out_sq    = sq_q;
	assign out_value = value_q;

endmodule

`default_nettype wire

@@ bench/rthp_hsv_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the RGB to HSV pixel converter: predicts each accepted pixel and
// compares every accepted HSV result in order. Depends on rthp_rgb_if and rthp_hsv_if.

module rthp_hsv_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	rthp_rgb_if  rgb_ch,
	rthp_hsv_if  hsv_ch,
	output int   mismatch_count,
	output int   due_count
);

	localparam int W = SAMPLE_BITS;

	typedef struct packed {
		logic [W-1:0] hue;
		logic [W-1:0] sat;
		logic [W-1:0] value;
	} hsv_pix_t;

	hsv_pix_t hsv_due[$];

	initial begin
		mismatch_count = 0;
		due_count      = 0;
	end

	// Compute the HSV triple that one RGB pixel must produce
	function automatic hsv_pix_t hsv_of_pixel(input logic [W-1:0] r, g, b);
		hsv_pix_t       px;
		logic [W-1:0]   top_c;
		logic [W-1:0]   low_c;
		logic [W-1:0]   span;
		logic [W+3:0]   rw, gw, bw, sw;
		logic [W+3:0]   turn_num;
		logic [W+3:0]   turn_den;
		logic [2*W+3:0] quo;
		px    = '0;
		top_c = r;
		low_c = r;
		if (g > top_c) top_c = g;
		if (b > top_c) top_c = b;
		if (g < low_c) low_c = g;
		if (b < low_c) low_c = b;
		span = top_c - low_c;
		rw   = r;
		gw   = g;
		bw   = b;
		sw   = span;

		// Hue: six sectors, blue wins ties over green, green over red
		if (span != 0) begin
			turn_den = sw * 6;
			if (b == top_c) begin
				turn_num = (sw * 4) + rw - gw;
			end else if (g == top_c) begin
				turn_num = (sw * 2) + bw - rw;
			end else if (g >= b) begin
				turn_num = gw - bw;
			end else begin
				turn_num = (sw * 6) - (bw - gw);
			end
			if (turn_num < turn_den) begin
				quo    = {turn_num, {W{1'b0}}} / {{W{1'b0}}, turn_den};
				px.hue = quo[W-1:0];
			end
		end

		// Saturation: delta over max, clamp when min is zero
		if (top_c != 0) begin
			if (span >= top_c) begin
				px.sat = '1;
			end else begin
				quo    = {{4{1'b0}}, span, {W{1'b0}}} / {{(W+4){1'b0}}, top_c};
				px.sat = quo[W-1:0];
			end
		end

		px.value = top_c;
		return px;
	endfunction

	// Print one line per mismatch and count
	task automatic flag_mismatch(input string what);
		$display("%0t ns hsv check: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Compare results first, then queue the prediction for a new pixel
	always @(posedge clk) begin
		hsv_pix_t want;
		if (arst_n) begin
			if (hsv_ch.valid === 1'b1 && hsv_ch.ready === 1'b1) begin
				if (hsv_due.size() == 0) begin
					flag_mismatch($sformatf("result h=%h s=%h v=%h with no pixel pending",
						hsv_ch.hue_out, hsv_ch.sat_out, hsv_ch.value_out));
				end else begin
					want = hsv_due.pop_front();
					if (hsv_ch.hue_out !== want.hue)
						flag_mismatch($sformatf("hue %h, want %h", hsv_ch.hue_out, want.hue));
					if (hsv_ch.sat_out !== want.sat)
						flag_mismatch($sformatf("sat %h, want %h", hsv_ch.sat_out, want.sat));
					if (hsv_ch.value_out !== want.value)
						flag_mismatch($sformatf("value %h, want %h",
							hsv_ch.value_out, want.value));
				end
			end
			if (rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1) begin
				hsv_due.push_back(hsv_of_pixel(rgb_ch.red_in, rgb_ch.green_in,
					rgb_ch.blue_in));
			end
			due_count <= hsv_due.size();
		end
	end

endmodule

@@ bench/tb_rgb_to_hsv_pixel.sv @@
`timescale 1ns / 1ps
// Top of the RGB to HSV pixel converter bench: clock, reset, pixel stimulus and
// output backpressure. Depends on rgb_to_hsv_pixel, its interfaces and rthp_hsv_checker.

module tb_rgb_to_hsv_pixel;

	localparam int          SAMPLE_BITS = 16;
	localparam int unsigned MASK        = 32'hffff_ffff >> (32 - SAMPLE_BITS);
	localparam int          PER_PHASE   = 150;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   due_count;
	int   send_gap_pct;
	int   recv_stall_pct;

	rthp_rgb_if #(.SAMPLE_BITS(SAMPLE_BITS)) rgb_ch ();
	rthp_hsv_if #(.SAMPLE_BITS(SAMPLE_BITS)) hsv_ch ();

	rgb_to_hsv_pixel #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (rgb_ch),
		.pix_out (hsv_ch)
	);

	rthp_hsv_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rgb_ch         (rgb_ch),
		.hsv_ch         (hsv_ch),
		.mismatch_count (mismatch_count),
		.due_count      (due_count)
	);

	always #1 clk = ~clk;

	// Stall the result channel at random
	always @(negedge clk) begin
		hsv_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Give up on a hung run
	initial begin
		#1_000_000;
		$display("[rgb_to_hsv_pixel] ERROR");
		$finish;
	end

	// Offer one pixel after random gaps and hold it until the transaction; call at negedge
	task automatic send_pixel(input int unsigned r, g, b);
		while ($urandom_range(99) < send_gap_pct) begin
			rgb_ch.valid    <= 1'b0;
			rgb_ch.red_in   <= $urandom;
			rgb_ch.green_in <= $urandom;
			rgb_ch.blue_in  <= $urandom;
			@(negedge clk);
		end
		rgb_ch.valid    <= 1'b1;
		rgb_ch.red_in   <= r[SAMPLE_BITS-1:0];
		rgb_ch.green_in <= g[SAMPLE_BITS-1:0];
		rgb_ch.blue_in  <= b[SAMPLE_BITS-1:0];
		@(posedge clk);
		while (rgb_ch.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned r, g, b, m, kind;
		arst_n          = 1'b0;
		send_gap_pct    = 37;
		recv_stall_pct  = 84;
		rgb_ch.valid    = 1'b0;
		rgb_ch.red_in   = '0;
		rgb_ch.green_in = '0;
		rgb_ch.blue_in  = '0;
		hsv_ch.ready    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Corners: black, white, gray, primaries, ties, both red half-sectors, tiny deltas
		send_pixel(0, 0, 0);
		send_pixel(MASK, MASK, MASK);
		send_pixel(32'h8000, 32'h8000, 32'h8000);
		send_pixel(MASK, 0, 0);
		send_pixel(0, MASK, 0);
		send_pixel(0, 0, MASK);
		send_pixel(MASK, MASK, 0);
		send_pixel(0, MASK, MASK);
		send_pixel(MASK, 0, MASK);
		send_pixel(MASK, 32'h1234, 32'h5678);
		send_pixel(MASK, 32'h5678, 32'h1234);
		send_pixel(MASK, 32'h4000, 32'h4000);
		send_pixel(1, 0, 0);
		send_pixel(2, 1, 1);
		send_pixel(32'h8000, 32'h7fff, 32'h7fff);
		send_pixel(MASK, MASK - 1, 0);
		send_pixel(32'h5555, 32'haaaa, 32'h5555);
		send_pixel(32'haaaa, 32'h5555, 32'haaaa);
		send_pixel(1, 1, 0);
		send_pixel(32'h1234, 32'hfedc, 1);
		send_pixel(1, 2, MASK);

		// Random pixels in three pacing phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct   = 37;
					recv_stall_pct = 84;
				end
				1: begin
					send_gap_pct   = 84;
					recv_stall_pct = 37;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int i = 0; i < PER_PHASE; i++) begin
				kind = $urandom_range(9);
				r    = $urandom & MASK;
				g    = $urandom & MASK;
				b    = $urandom & MASK;
				m    = $urandom & MASK;
				case (kind)
					3: begin
						// near gray: small spread around a random level
						g = (r + $urandom_range(3)) & MASK;
						b = (r + $urandom_range(3)) & MASK;
					end
					4: begin
						// two channels tie at the top
						case ($urandom_range(2))
							0: begin r = m; g = m; b = $urandom_range(m); end
							1: begin g = m; b = m; r = $urandom_range(m); end
							default: begin r = m; b = m; g = $urandom_range(m); end
						endcase
					end
					5: begin
						// one channel at zero: full saturation
						case ($urandom_range(2))
							0: r = 0;
							1: g = 0;
							default: b = 0;
						endcase
					end
					6: begin
						r = m;
						g = m;
						b = m;
					end
					7: begin
						// mix of range extremes
						case ($urandom_range(4))
							0: r = 0;
							1: r = 1;
							2: r = MASK - 1;
							3: r = MASK;
							default: ;
						endcase
						case ($urandom_range(4))
							0: g = 0;
							1: g = 1;
							2: g = MASK - 1;
							3: g = MASK;
							default: ;
						endcase
						case ($urandom_range(4))
							0: b = 0;
							1: b = 1;
							2: b = MASK - 1;
							3: b = MASK;
							default: ;
						endcase
					end
					8, 9: begin
						// dim pixels to work the low bits
						m = $urandom_range(SAMPLE_BITS - 1);
						r = r >> m;
						g = g >> m;
						b = b >> m;
					end
					default: ;
				endcase
				send_pixel(r, g, b);
			end
		end
		rgb_ch.valid <= 1'b0;

		// Drain the pipeline, then let stragglers show up
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (2 * SAMPLE_BITS + 8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("[rgb_to_hsv_pixel] OK");
		end else begin
			$display("[rgb_to_hsv_pixel] ERROR");
		end
		$finish;
	end

endmodule
